// ===== rtl/wfu_pkg.sv =====
// Shared types and constants for the frame unmasker.
package wfu_pkg;

	// Depth of the queue between parser and unmask stage
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One payload beat handed from parser to unmask stage
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] mask;
		logic       last;
	} entry_t;

endpackage

// ===== rtl/wfu_parser.sv =====
// Front end: header parsing, length and mask key capture, payload classification.
module wfu_parser #(
	parameter int LENGTH_BITS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pass_opcode_we,
	input  logic [3:0]          pass_opcode,
	input  logic                accept,
	input  logic [7:0]          rx_byte,
	output logic                q_push,
	output wfu_pkg::entry_t     q_entry
);

	localparam logic [2:0] PH_OPCODE  = 3'd0;
	localparam logic [2:0] PH_LEN     = 3'd1;
	localparam logic [2:0] PH_EXT     = 3'd2;
	localparam logic [2:0] PH_MASK    = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	localparam logic [LENGTH_BITS-1:0] LEN_ZERO = '0;
	localparam logic [LENGTH_BITS-1:0] LEN_ONE  = {{(LENGTH_BITS-1){1'b0}}, 1'b1};

	logic [3:0]             pass_opcode_q;
	logic [2:0]             phase_q;
	logic                   passes_q;
	logic [3:0]             ext_left_q;
	logic [LENGTH_BITS-1:0] rem_q;
	logic [31:0]            key_q;
	logic [1:0]             idx_q;

	logic [3:0]             ext_dec;
	logic [7:0]             mask_byte;
	logic                   is_last;

	assign ext_dec = ext_left_q - 4'd1;
	assign is_last = (rem_q == LEN_ONE);

	// Key byte for the current payload position, first key byte at the top
	always_comb begin
		unique case (idx_q)
			2'd0: mask_byte = key_q[31:24];
			2'd1: mask_byte = key_q[23:16];
			2'd2: mask_byte = key_q[15:8];
			default: mask_byte = key_q[7:0];
		endcase
	end

	// Passing payload beats go to the queue
	assign q_push       = accept && (phase_q == PH_PAYLOAD) && passes_q;
	assign q_entry.data = rx_byte;
	assign q_entry.mask = mask_byte;
	assign q_entry.last = is_last;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_opcode_q <= 4'd1;
		end else if (pass_opcode_we) begin
			pass_opcode_q <= pass_opcode;
		end
	end

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_OPCODE;
			passes_q   <= 1'b0;
			ext_left_q <= 4'd0;
			rem_q      <= LEN_ZERO;
			key_q      <= 32'd0;
			idx_q      <= 2'd0;
		end else if (accept) begin
			unique case (phase_q)
				PH_LEN: begin
					rem_q <= LEN_ZERO;
					if (rx_byte[6:0] == LEN_EXT16) begin
						phase_q    <= PH_EXT;
						ext_left_q <= 4'd2;
					end else if (rx_byte[6:0] == LEN_EXT64) begin
						phase_q    <= PH_EXT;
						ext_left_q <= 4'd8;
					end else begin
						rem_q      <= {{(LENGTH_BITS-7){1'b0}}, rx_byte[6:0]};
						phase_q    <= PH_MASK;
						ext_left_q <= 4'd4;
						key_q      <= 32'd0;
						idx_q      <= 2'd0;
					end
				end
				PH_EXT: begin
					rem_q      <= {rem_q[LENGTH_BITS-9:0], rx_byte};
					ext_left_q <= ext_dec;
					if (ext_dec == 4'd0) begin
						phase_q    <= PH_MASK;
						ext_left_q <= 4'd4;
						key_q      <= 32'd0;
						idx_q      <= 2'd0;
					end
				end
				PH_MASK: begin
					key_q      <= {key_q[23:0], rx_byte};
					ext_left_q <= ext_dec;
					if (ext_dec == 4'd0) begin
						idx_q   <= 2'd0;
						phase_q <= (rem_q == LEN_ZERO) ? PH_OPCODE : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					idx_q <= idx_q + 2'd1;
					rem_q <= rem_q - LEN_ONE;
					if (is_last) begin
						phase_q <= PH_OPCODE;
					end
				end
				default: begin
					// opcode byte; unused phase codes land here too
					passes_q <= (rx_byte[3:0] == pass_opcode_q);
					phase_q  <= PH_LEN;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_ext_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_EXT || phase_q == PH_MASK) |-> (ext_left_q != 4'd0))
		else $error("extended length or key phase with zero byte count");
	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (rem_q != LEN_ZERO))
		else $error("payload phase with zero remaining length");
	a_push_phase: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (passes_q && $past(phase_q) != PH_OPCODE))
		else $error("push outside a passing frame payload");
`endif

endmodule

// ===== rtl/wfu_queue.sv =====
// Small register queue between parser and unmask stage.
module wfu_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wfu_pkg::entry_t wr_entry,
	output logic            full,
	input  logic            pop,
	output wfu_pkg::entry_t rd_entry,
	output logic            empty
);

	wfu_pkg::entry_t                slots_q [wfu_pkg::QDEPTH];
	logic [wfu_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [wfu_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [wfu_pkg::QCNT_W-1:0]     count_q;

	logic do_push;
	logic do_pop;

	assign full     = (count_q == wfu_pkg::QCNT_W'(wfu_pkg::QDEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_entry = slots_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= wfu_pkg::QCNT_W'(wfu_pkg::QDEPTH))
		else $error("queue count beyond depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != wfu_pkg::QCNT_W'(wfu_pkg::QDEPTH)) |->
		(wfu_pkg::QPTR_W'(wr_ptr_q - rd_ptr_q) == count_q[wfu_pkg::QPTR_W-1:0]))
		else $error("queue pointers disagree with count");
`endif

endmodule

// ===== rtl/wfu_unmask.sv =====
// Back end: XOR with the key byte and hold the result in the output register.
module wfu_unmask (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  wfu_pkg::entry_t q_entry,
	output logic            q_pop,
	output logic [7:0]      payload_byte,
	output logic            last_of_frame,
	output logic            empty,
	input  logic            pop
);

	logic       valid_q;
	logic [7:0] data_q;
	logic       last_q;

	// Refill when the output register is free or being drained
	assign q_pop = !q_empty && (!valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_q <= q_entry.data ^ q_entry.mask;
			last_q <= q_entry.last;
		end
	end

	assign empty         = !valid_q;
	assign payload_byte  = data_q;
	assign last_of_frame = last_q;

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !pop) |=> (valid_q && $stable(data_q) && $stable(last_q)))
		else $error("output beat changed while waiting");
`endif

endmodule

// ===== rtl/websocket_frame_unmasker_top.sv =====
// Top level of the frame unmasker: parser, queue and unmask stage.
// Throughput: one received byte per cycle with no gaps between frames; full rises only
// when the four-entry queue fills because results are not being popped.
// Path: a passing payload byte is written into the queue when accepted and moves to the
// output register once that register is free or being popped; the result ports show that register.
// Reset: arst_n clears parse state, queue and output valid; pass_opcode returns to 1.
module websocket_frame_unmasker_top #(
	parameter int LENGTH_BITS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pass_opcode_we,
	input  logic [3:0] pass_opcode,
	input  logic       push,
	input  logic [7:0] rx_byte,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] payload_byte,
	output logic       last_of_frame
);

	logic            accept;
	logic            q_push;
	wfu_pkg::entry_t q_wr_entry;
	logic            q_full;
	logic            q_pop;
	wfu_pkg::entry_t q_rd_entry;
	logic            q_empty;

	assign full   = q_full;
	assign accept = push && !q_full;

	wfu_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.pass_opcode_we (pass_opcode_we),
		.pass_opcode    (pass_opcode),
		.accept         (accept),
		.rx_byte        (rx_byte),
		.q_push         (q_push),
		.q_entry        (q_wr_entry)
	);

	wfu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr_entry),
		.full     (q_full),
		.pop      (q_pop),
		.rd_entry (q_rd_entry),
		.empty    (q_empty)
	);

	wfu_unmask u_unmask (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_entry       (q_rd_entry),
		.q_pop         (q_pop),
		.payload_byte  (payload_byte),
		.last_of_frame (last_of_frame),
		.empty         (empty),
		.pop           (pop)
	);

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for the frame unmasker: random client frame streams checked by a byte-level predictor.

class unmask_scoreboard;
	localparam int LEN_W = 64;
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	typedef enum logic [2:0] {PH_HEADER, PH_LENGTH, PH_EXTLEN, PH_KEY, PH_DATA} parse_phase_e;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} unmasked_t;

	parse_phase_e     phase;
	logic             passes;
	logic [3:0]       ext_left;
	logic [LEN_W-1:0] remaining;
	logic [31:0]      key;
	logic [1:0]       key_idx;
	logic [3:0]       opcode_sel;
	unmasked_t        expected_q[$];
	int               mismatches;

	function new();
		phase      = PH_HEADER;
		passes     = 1'b0;
		ext_left   = '0;
		remaining  = '0;
		key        = '0;
		key_idx    = '0;
		opcode_sel = 4'd1;
		mismatches = 0;
	endfunction

	function void set_pass_opcode(logic [3:0] v);
		opcode_sel = v;
	endfunction

	function void begin_key();
		phase    = PH_KEY;
		ext_left = 4'd4;
		key      = '0;
		key_idx  = '0;
	endfunction

	// Advance the parse state by one accepted byte, queue any unmasked beat
	function void note_rx_byte(logic [7:0] b);
		logic [7:0] key_byte;
		unmasked_t  beat;
		case (phase)
			PH_LENGTH: begin
				remaining = '0;
				if (b[6:0] == LEN_EXT16) begin
					phase    = PH_EXTLEN;
					ext_left = 4'd2;
				end else if (b[6:0] == LEN_EXT64) begin
					phase    = PH_EXTLEN;
					ext_left = 4'd8;
				end else begin
					remaining = LEN_W'(b[6:0]);
					begin_key();
				end
			end
			PH_EXTLEN: begin
				remaining = {remaining[LEN_W-9:0], b};
				ext_left  = ext_left - 4'd1;
				if (ext_left == 4'd0)
					begin_key();
			end
			PH_KEY: begin
				key      = {key[23:0], b};
				ext_left = ext_left - 4'd1;
				if (ext_left == 4'd0) begin
					key_idx = '0;
					phase   = (remaining == '0) ? PH_HEADER : PH_DATA;
				end
			end
			PH_DATA: begin
				key_byte = 8'(key >> (8 * (3 - key_idx)));
				if (passes) begin
					beat.data = b ^ key_byte;
					beat.last = (remaining == LEN_W'(1));
					expected_q.insert(expected_q.size(), beat);
				end
				key_idx   = key_idx + 2'd1;
				remaining = remaining - LEN_W'(1);
				if (remaining == '0)
					phase = PH_HEADER;
			end
			// header byte; unused phase codes land here too
			default: begin
				passes = (b[3:0] == opcode_sel);
				phase  = PH_LENGTH;
			end
		endcase
	endfunction

	// Compare one popped beat with the oldest expectation
	function void check_payload(logic [7:0] data, logic last);
		unmasked_t want;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected beat: data %02h last %0d", data, last);
			return;
		end
		want = expected_q.pop_front();
		if (want.data !== data || want.last !== last) begin
			mismatches++;
			if (mismatches <= 10)
				$display("beat mismatch: expected data %02h last %0d, got data %02h last %0d",
					want.data, want.last, data, last);
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module tb;
	typedef enum {ENC_SHORT, ENC_EXT16, ENC_EXT64} len_enc_e;

	// Length byte codes that announce an extended length
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       pass_opcode_we;
	logic [3:0] pass_opcode;
	logic       push;
	logic [7:0] rx_byte;
	logic       full;
	logic       pop;
	logic       empty;
	logic [7:0] payload_byte;
	logic       last_of_frame;

	unmask_scoreboard sb = new();

	bit         quiet;
	bit         rx_hold_req;
	int         rx_bytes_sent;
	logic [3:0] cur_opcode;

	websocket_frame_unmasker_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.pass_opcode_we (pass_opcode_we),
		.pass_opcode    (pass_opcode),
		.push           (push),
		.rx_byte        (rx_byte),
		.full           (full),
		.pop            (pop),
		.empty          (empty),
		.payload_byte   (payload_byte),
		.last_of_frame  (last_of_frame)
	);

	always #5 clk = ~clk;

	function bit idle_roll();
		return !quiet && ($urandom_range(99) < 29);
	endfunction

	// Offer one byte, hold it until the block takes it
	task push_byte(logic [7:0] b);
		while (idle_roll()) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_rx_byte(b);
		rx_bytes_sent++;
	endtask

	// Header, length in the chosen encoding, key, payload; flag bits random
	task send_frame(logic [3:0] opc, int len, len_enc_e enc);
		logic [63:0] len64;
		int          i;
		len64 = 64'(len);
		push_byte({4'($urandom), opc});
		case (enc)
			ENC_SHORT: push_byte({1'($urandom), 7'(len)});
			ENC_EXT16: begin
				push_byte({1'($urandom), LEN_EXT16});
				push_byte(len64[15:8]);
				push_byte(len64[7:0]);
			end
			default: begin
				push_byte({1'($urandom), LEN_EXT64});
				for (i = 7; i >= 0; i--)
					push_byte(len64[8*i +: 8]);
			end
		endcase
		repeat (4) push_byte(8'($urandom));
		repeat (len) push_byte(8'($urandom));
	endtask

	// Mostly short frames, a few long ones and extended encodings
	task run_phase(int n_bytes);
		int         stop_at;
		int         roll;
		int         len;
		len_enc_e   enc;
		logic [3:0] opc;
		stop_at = rx_bytes_sent + n_bytes;
		while (rx_bytes_sent < stop_at) begin
			roll = $urandom_range(99);
			opc  = ($urandom_range(99) < 60) ? cur_opcode : 4'($urandom);
			enc  = ENC_SHORT;
			if (roll < 10)
				len = 0;
			else if (roll < 80)
				len = $urandom_range(16, 1);
			else if (roll < 90)
				len = $urandom_range(125, 17);
			else if (roll < 97) begin
				len = $urandom_range(300, 0);
				enc = ENC_EXT16;
			end else begin
				len = $urandom_range(40, 0);
				enc = ENC_EXT64;
			end
			send_frame(opc, len, enc);
		end
	endtask

	// Drain all results, let the parser settle, then change the passed opcode
	task settle_and_set(logic [3:0] v);
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		pass_opcode_we <= 1'b1;
		pass_opcode    <= v;
		@(posedge clk);
		pass_opcode_we <= 1'b0;
		sb.set_pass_opcode(v);
		cur_opcode = v;
	endtask

	// Result side: random pops, one long hold-off on request
	initial begin
		forever begin
			if (rx_hold_req) begin
				pop <= 1'b0;
				repeat (80) @(posedge clk);
				rx_hold_req = 1'b0;
			end else begin
				pop <= !idle_roll();
				@(posedge clk);
				if (pop && !empty)
					sb.check_payload(payload_byte, last_of_frame);
			end
		end
	end

	// Stimulus and verdict
	initial begin
		arst_n         <= 1'b0;
		push           <= 1'b0;
		rx_byte        <= 8'h00;
		pass_opcode_we <= 1'b0;
		pass_opcode    <= 4'd1;
		cur_opcode     = 4'd1;
		quiet          = 1'b0;
		rx_hold_req    = 1'b0;
		rx_bytes_sent  = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// text frame, two bytes, key with all-ones and all-zeros bytes
		push_byte(8'h81);
		push_byte(8'h82);
		push_byte(8'hFF);
		push_byte(8'h00);
		push_byte(8'hA5);
		push_byte(8'h5A);
		push_byte(8'hFF);
		push_byte(8'h00);
		// zero-length text frame, mask bit clear
		push_byte(8'h01);
		push_byte(8'h00);
		repeat (4) push_byte(8'h00);
		// other opcode with RSV bits, 16-bit length, payload skipped
		push_byte(8'h72);
		push_byte(8'hFE);
		push_byte(8'h00);
		push_byte(8'h02);
		repeat (4) push_byte(8'($urandom));
		push_byte(8'hFF);
		push_byte(8'h00);

		run_phase(250);

		settle_and_set(4'd0);
		quiet = 1'b1;
		run_phase(250);
		quiet = 1'b0;

		// receiver holds off while a long frame streams in
		settle_and_set(4'd15);
		rx_hold_req = 1'b1;
		quiet       = 1'b1;
		send_frame(4'd15, 60, ENC_SHORT);
		quiet = 1'b0;
		run_phase(200);

		settle_and_set(4'd1);
		run_phase(250);
		settle_and_set(4'($urandom));
		run_phase(250);
		settle_and_set(4'($urandom));
		run_phase(300);

		push <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/wfu_pkg.sv
rtl/wfu_parser.sv
rtl/wfu_queue.sv
rtl/wfu_unmask.sv
rtl/websocket_frame_unmasker_top.sv
tb/tb.sv
